// File: sv/assert_macros.svh
// assertion macros shared by the linearizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/ntc_pkg.sv
// types, constants and segment tables for the thermistor linearizer
`default_nettype none

package ntc_pkg;

    // field and datapath widths
    localparam int unsigned MV_W        = 12;
    localparam int unsigned NUM_W       = 25;
    localparam int unsigned DEN_W       = 12;
    localparam int unsigned QUO_W       = 16;
    localparam int unsigned TRIAL_W     = 28;
    localparam int unsigned DIFF_W      = 14;
    localparam int unsigned X_W         = 24;
    localparam int unsigned RECIP_W     = 22;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned PROD_W      = X_W + RECIP_W;
    localparam int unsigned FRAC_W      = 10;
    localparam int unsigned KT_W        = 14;
    localparam int unsigned SEG_W       = 3;
    localparam int unsigned TEMP_W      = 13;

    // pipeline shape
    localparam int unsigned FRONT_STAGES = 2;
    localparam int unsigned DIV_BITS     = 2;
    localparam int unsigned DIV_STAGES   = QUO_W / DIV_BITS;
    localparam int unsigned SEG_STAGES   = 5;

    // divider and table constants
    localparam logic [MV_W-1:0]  C_SUPPLY_MV = 12'd3300;
    localparam logic [NUM_W-1:0] C_R_SERIES  = 25'd10000;
    localparam logic [QUO_W-1:0] C_R_TOP     = 16'd33970;
    localparam logic [QUO_W-1:0] C_R_BOTTOM  = 16'd2484;
    localparam logic [QUO_W-1:0] C_BP_10C    = 16'd20310;
    localparam logic [QUO_W-1:0] C_BP_20C    = 16'd12570;
    localparam logic [QUO_W-1:0] C_BP_30C    = 16'd8034;
    localparam logic [QUO_W-1:0] C_BP_40C    = 16'd5298;
    localparam logic [QUO_W-1:0] C_BP_50C    = 16'd3586;
    localparam logic [X_W-1:0]   C_FRAC_SCALE = 24'd1000;
    localparam logic [TEMP_W-1:0] C_TEMP_MAX  = 13'd6000;

    // partial division carried down the divider stages
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             bad;
    } t_div;

    // upper resistance bound of each segment
    function automatic logic [QUO_W-1:0] seg_hi(input logic [SEG_W-1:0] seg);
        logic [QUO_W-1:0] v;
        case (seg)
            3'd0:    v = C_R_TOP;
            3'd1:    v = C_BP_10C;
            3'd2:    v = C_BP_20C;
            3'd3:    v = C_BP_30C;
            3'd4:    v = C_BP_40C;
            3'd5:    v = C_BP_50C;
            default: v = '0;
        endcase
        return v;
    endfunction

    // slope in tenths of an ohm per degree
    function automatic logic [KT_W-1:0] seg_kt(input logic [SEG_W-1:0] seg);
        logic [KT_W-1:0] v;
        case (seg)
            3'd0:    v = 14'd13660;
            3'd1:    v = 14'd7740;
            3'd2:    v = 14'd4537;
            3'd3:    v = 14'd2737;
            3'd4:    v = 14'd1717;
            3'd5:    v = 14'd1102;
            default: v = 14'd1;
        endcase
        return v;
    endfunction

    // floor(2^32 / slope), estimate is low by at most one
    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
        logic [RECIP_W-1:0] v;
        case (seg)
            3'd0:    v = 22'd314419;
            3'd1:    v = 22'd554905;
            3'd2:    v = 22'd946653;
            3'd3:    v = 22'd1569224;
            3'd4:    v = 22'd2501436;
            3'd5:    v = 22'd3897429;
            default: v = '0;
        endcase
        return v;
    endfunction

    // base temperature of each segment in hundredths of a degree
    function automatic logic [TEMP_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
        logic [TEMP_W-1:0] v;
        case (seg)
            3'd0:    v = 13'd0;
            3'd1:    v = 13'd1000;
            3'd2:    v = 13'd2000;
            3'd3:    v = 13'd3000;
            3'd4:    v = 13'd4000;
            3'd5:    v = 13'd5000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/ntc_front.sv
// front stages: scaled numerator, divisor and quotient overflow check
`default_nettype none

module ntc_front (
    input  wire logic                      i_clk,
    input  wire logic [1:0]                i_en,
    input  wire logic [ntc_pkg::MV_W-1:0]  i_millivolts,
    output ntc_pkg::t_div                  o_div
);
    import ntc_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic             r_bad;
    t_div             r_div;
    logic             n_ovf;

    // stage one: mv * 10000 and supply - mv
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num <= NUM_W'(i_millivolts) * C_R_SERIES;
            r_den <= C_SUPPLY_MV - i_millivolts;
            r_bad <= (i_millivolts >= C_SUPPLY_MV);
        end
    end

    // quotient of 2^16 or more is far outside the table
    assign n_ovf = (TRIAL_W'(r_num) >= {r_den, {QUO_W{1'b0}}});

    // stage two: seed the divider
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_div.rem <= r_num;
            r_div.den <= r_den;
            r_div.quo <= '0;
            r_div.bad <= r_bad || n_ovf;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

// File: sv/ntc_div_stage.sv
// one restoring divider stage, two quotient bits per stage
`default_nettype none

module ntc_div_stage #(
    parameter int unsigned P_LSB = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire ntc_pkg::t_div i_div,
    output ntc_pkg::t_div o_div
);
    import ntc_pkg::*;

    t_div               n_div;
    t_div               r_div;
    logic [TRIAL_W-1:0] trial;

    // trial subtract of the shifted divisor, high bit first
    always_comb begin
        n_div = i_div;
        trial = '0;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            trial = TRIAL_W'(n_div.den) << (P_LSB + b);
            if (TRIAL_W'(n_div.rem) >= trial) begin
                n_div.rem = NUM_W'(TRIAL_W'(n_div.rem) - trial);
                n_div.quo = n_div.quo | (QUO_W'(1) << (P_LSB + b));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

// File: sv/ntc_seg.sv
// segment lookup and slope division by reciprocal, ends in the output register
`default_nettype none

module ntc_seg (
    input  wire logic                          i_clk,
    input  wire logic [ntc_pkg::SEG_STAGES-1:0] i_en,
    input  wire logic [ntc_pkg::QUO_W-1:0]      i_quo,
    input  wire logic                          i_bad,
    output logic [ntc_pkg::TEMP_W-1:0]          o_temp_centi,
    output logic                               o_out_of_range
);
    import ntc_pkg::*;

    logic [SEG_W-1:0]  n_seg1, r_seg1, r_seg2, r_seg3, r_seg4;
    logic [DIFF_W-1:0] n_diff1, r_diff1;
    logic              n_oor1, r_oor1, r_oor2, r_oor3, r_oor4, r_oor5;
    logic [X_W-1:0]    r_x2, r_x3, r_x4;
    logic [PROD_W-1:0] n_prod3;
    logic [FRAC_W-1:0] r_qe3, r_qe4, n_frac5;
    logic [X_W-1:0]    r_p4, n_rem5;
    logic [TEMP_W-1:0] r_temp5;

    // stage one: range check, segment pick, distance below the segment top
    always_comb begin
        n_oor1 = i_bad || (i_quo >= C_R_TOP) || (i_quo <= C_R_BOTTOM);
        n_seg1 = SEG_W'(i_quo <= C_BP_10C) + SEG_W'(i_quo <= C_BP_20C)
               + SEG_W'(i_quo <= C_BP_30C) + SEG_W'(i_quo <= C_BP_40C)
               + SEG_W'(i_quo <= C_BP_50C);
        n_diff1 = DIFF_W'(seg_hi(n_seg1) - i_quo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_seg1  <= n_seg1;
            r_diff1 <= n_diff1;
            r_oor1  <= n_oor1;
        end
    end

    // stage two: scale the distance to thousandths
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x2   <= X_W'(r_diff1) * C_FRAC_SCALE;
            r_seg2 <= r_seg1;
            r_oor2 <= r_oor1;
        end
    end

    // stage three: quotient estimate through the slope reciprocal
    assign n_prod3 = PROD_W'(r_x2) * PROD_W'(seg_recip(r_seg2));

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_qe3  <= n_prod3[RECIP_SHIFT +: FRAC_W];
            r_x3   <= r_x2;
            r_seg3 <= r_seg2;
            r_oor3 <= r_oor2;
        end
    end

    // stage four: back-multiply the estimate
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_p4   <= X_W'(r_qe3) * X_W'(seg_kt(r_seg3));
            r_qe4  <= r_qe3;
            r_x4   <= r_x3;
            r_seg4 <= r_seg3;
            r_oor4 <= r_oor3;
        end
    end

    // stage five: correct the estimate by one and add the base temperature, or give zero when out of range
    always_comb begin
        n_rem5  = r_x4 - r_p4;
        n_frac5 = r_qe4 + FRAC_W'(n_rem5 >= X_W'(seg_kt(r_seg4)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_temp5 <= r_oor4 ? '0 : (seg_base(r_seg4) + TEMP_W'(n_frac5));
            r_oor5  <= r_oor4;
        end
    end

    assign o_temp_centi   = r_temp5;
    assign o_out_of_range = r_oor5;

endmodule

`default_nettype wire

// File: sv/ntc_thermistor_linearizer.sv
// top level of the ntc thermistor linearizer pipeline
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  input    | in        | i_in_valid / o_in_ready    | i_millivolts
//  output   | out       | o_out_valid / i_out_ready  | o_temp_centi, o_out_of_range
//
// one transaction in per cycle, one transaction out per cycle when nothing stalls
// pipeline stages: 2 front stages, 8 divider stages of 2 quotient bits, 5 segment stages
// the 16-bit resistance quotient from the restoring divider sets the pipeline depth
// reset clears only the stage valid bits, the payload registers are not reset
// a stage holds while the next one is full and stalled, so empty stages fill up behind a
// stalled output and nothing is lost or repeated
`default_nettype none
`include "assert_macros.svh"

module ntc_thermistor_linearizer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [ntc_pkg::MV_W-1:0]   i_millivolts,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [ntc_pkg::TEMP_W-1:0]      o_temp_centi,
    output logic                            o_out_of_range
);
    import ntc_pkg::*;

    localparam int unsigned NST = FRONT_STAGES + DIV_STAGES + SEG_STAGES;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] en;
    t_div           w_div [DIV_STAGES+1];

    // a stage may load when it is empty or the one after it moves on
    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // valid bits shift along with the data
    assign n_v = {r_v[NST-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (en & n_v) | (~en & r_v);
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NST-1];

    // numerator, divisor and overflow
    ntc_front u_front (
        .i_clk        (i_clk),
        .i_en         (en[FRONT_STAGES-1:0]),
        .i_millivolts (i_millivolts),
        .o_div        (w_div[0])
    );

    // resistance quotient, high bits first
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ntc_div_stage #(
            .P_LSB (QUO_W - DIV_BITS * (g + 1))
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en[FRONT_STAGES + g]),
            .i_div (w_div[g]),
            .o_div (w_div[g+1])
        );
    end

    // segment mapping and output register
    ntc_seg u_seg (
        .i_clk          (i_clk),
        .i_en           (en[NST-1 -: SEG_STAGES]),
        .i_quo          (w_div[DIV_STAGES].quo),
        .i_bad          (w_div[DIV_STAGES].bad),
        .o_temp_centi   (o_temp_centi),
        .o_out_of_range (o_out_of_range)
    );

    // flagged results carry a zero temperature
    `ASSERT_IMPLIES(a_oor_zero, i_clk, i_rst_n, o_out_valid && o_out_of_range, o_temp_centi == '0)
    // in-range results stay below sixty degrees
    `ASSERT_IMPLIES(a_temp_max, i_clk, i_rst_n, o_out_valid && !o_out_of_range, o_temp_centi < C_TEMP_MAX)
    // reset empties the pipeline
    `ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking testbench for the ntc thermistor linearizer pipeline
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MV_W   = ntc_pkg::MV_W;
    localparam int unsigned TEMP_W = ntc_pkg::TEMP_W;

    localparam int unsigned SUPPLY_MV   = 3300;
    localparam int unsigned SERIES_OHMS = 10000;
    localparam int unsigned OHMS_TOP    = 33970;
    localparam int unsigned OHMS_BOTTOM = 2484;
    localparam int          NUM_SEGS    = 6;

    // segment bounds in ohms and slopes in tenths of an ohm per degree
    localparam int unsigned SEG_UPPER [NUM_SEGS] = '{33970, 20310, 12570, 8034, 5298, 3586};
    localparam int unsigned SEG_LOWER [NUM_SEGS] = '{20310, 12570, 8034, 5298, 3586, 2484};
    localparam int unsigned SEG_SLOPE [NUM_SEGS] = '{13660, 7740, 4537, 2737, 1717, 1102};

    localparam int NUM_RANDOM   = 1450;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    // pacing of both channels
    typedef enum logic [1:0] {
        PACE_STEADY = 2'd0,
        PACE_LIGHT  = 2'd1,
        PACE_HEAVY  = 2'd2
    } t_pace;

    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic [TEMP_W-1:0] temp;
        logic              oor;
    } t_reading;

    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic              typed;
        logic [TEMP_W-1:0] temp;
        logic              oor;
    } t_probe;

    // directed probes: supply and table edges, neighbors of every breakpoint, bit patterns
    localparam int NUM_PROBES = 25;
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{12'd0,    1'b1, 13'd0,    1'b1},
        '{12'd1,    1'b1, 13'd0,    1'b1},
        '{12'd656,  1'b1, 13'd0,    1'b1},
        '{12'd657,  1'b1, 13'd5999, 1'b0},
        '{12'd871,  1'b0, 13'd0,    1'b0},
        '{12'd872,  1'b0, 13'd0,    1'b0},
        '{12'd1142, 1'b0, 13'd0,    1'b0},
        '{12'd1143, 1'b0, 13'd0,    1'b0},
        '{12'd1470, 1'b0, 13'd0,    1'b0},
        '{12'd1471, 1'b0, 13'd0,    1'b0},
        '{12'd1650, 1'b0, 13'd0,    1'b0},
        '{12'd1837, 1'b0, 13'd0,    1'b0},
        '{12'd1838, 1'b0, 13'd0,    1'b0},
        '{12'd2211, 1'b0, 13'd0,    1'b0},
        '{12'd2212, 1'b0, 13'd0,    1'b0},
        '{12'd2549, 1'b1, 13'd2,    1'b0},
        '{12'd2550, 1'b1, 13'd0,    1'b1},
        '{12'd3299, 1'b1, 13'd0,    1'b1},
        '{12'd3300, 1'b1, 13'd0,    1'b1},
        '{12'd3301, 1'b1, 13'd0,    1'b1},
        '{12'd4094, 1'b1, 13'd0,    1'b1},
        '{12'd4095, 1'b1, 13'd0,    1'b1},
        '{12'd2048, 1'b0, 13'd0,    1'b0},
        '{12'd1365, 1'b0, 13'd0,    1'b0},
        '{12'd2730, 1'b0, 13'd0,    1'b0}
    };

    // voltages next to the table edges and breakpoints
    localparam int NUM_EDGES = 16;
    localparam int unsigned EDGE_MV [NUM_EDGES] = '{656, 657, 871, 872, 1142, 1143, 1470,
        1471, 1837, 1838, 2211, 2212, 2549, 2550, 3299, 3300};

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              in_valid       = 1'b0;
    logic [MV_W-1:0]   in_mv          = '0;
    logic              out_ready      = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [TEMP_W-1:0] o_temp_centi;
    logic              o_out_of_range;

    t_pace    pace        = PACE_STEADY;
    int       ready_hold  = 0;
    int       error_count = 0;
    int       cycle_count = 0;
    t_reading pending_readings [$];

    ntc_thermistor_linearizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_millivolts   (in_mv),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_temp_centi   (o_temp_centi),
        .o_out_of_range (o_out_of_range)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d results outstanding", $time,
                     pending_readings.size());
            $display("ntc_thermistor_linearizer verification failed");
            $finish;
        end
    end

    // divider resistance, segment lookup and truncated interpolation
    function automatic t_reading predict_temperature(input logic [MV_W-1:0] mv);
        t_reading    res;
        int unsigned volts;
        int unsigned ohms;
        int unsigned frac;
        res.mv   = mv;
        res.temp = '0;
        res.oor  = 1'b1;
        volts    = mv;
        if (volts < SUPPLY_MV) begin
            ohms = (volts * SERIES_OHMS) / (SUPPLY_MV - volts);
            if (ohms < OHMS_TOP && ohms > OHMS_BOTTOM) begin
                for (int s = 0; s < NUM_SEGS; s++) begin
                    if (ohms > SEG_LOWER[s] && ohms <= SEG_UPPER[s]) begin
                        frac     = ((SEG_UPPER[s] - ohms) * 1000) / SEG_SLOPE[s];
                        res.temp = TEMP_W'(s * 1000 + frac);
                        res.oor  = 1'b0;
                        break;
                    end
                end
            end
        end
        return res;
    endfunction

    // idle length before the next input transaction
    function automatic int pick_gap(input t_pace p);
        int roll;
        roll = $urandom_range(0, 99);
        if (p == PACE_STEADY)
            return 0;
        if (roll < (p == PACE_LIGHT ? 65 : 40))
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one input transaction, expectation queued at acceptance
    task automatic send_reading(input t_probe p);
        int       gap;
        t_reading exp_res;
        gap = pick_gap(pace);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_mv    <= p.mv;
        do @(posedge i_clk); while (!o_in_ready);
        if (p.typed) begin
            exp_res.mv   = p.mv;
            exp_res.temp = p.temp;
            exp_res.oor  = p.oor;
        end else begin
            exp_res = predict_temperature(p.mv);
        end
        pending_readings.push_back(exp_res);
    endtask

    // hold the sender until every expected result has come
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // output ready pattern
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (pace == PACE_STEADY) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < (pace == PACE_LIGHT ? 70 : 45)) begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            out_ready  <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    // compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_reading exp_res;
        if (i_rst_n && o_out_valid === 1'b1 && out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result temp %0d oor %0d", $time,
                         o_temp_centi, o_out_of_range);
                error_count = error_count + 1;
            end else begin
                exp_res = pending_readings.pop_front();
                if (o_temp_centi !== exp_res.temp) begin
                    $display("%0t: mv %0d temp_centi expected %0d actual %0d", $time,
                             exp_res.mv, exp_res.temp, o_temp_centi);
                    error_count = error_count + 1;
                end
                if (o_out_of_range !== exp_res.oor) begin
                    $display("%0t: mv %0d out_of_range expected %0d actual %0d", $time,
                             exp_res.mv, exp_res.oor, o_out_of_range);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_probe p;
        int     roll;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed probes back to back, then a full drain
        for (int n = 0; n < NUM_PROBES; n++)
            send_reading(PROBES[n]);
        wait_drained();

        // random readings, mostly inside the table
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 100 == 0)
                pace <= (n == 0) ? PACE_STEADY : t_pace'($urandom_range(0, 2));
            if (n == NUM_RANDOM / 2)
                wait_drained();
            roll    = $urandom_range(0, 99);
            p.typed = 1'b0;
            p.temp  = '0;
            p.oor   = 1'b0;
            if (roll < 65)
                p.mv = MV_W'($urandom_range(657, 2549));
            else if (roll < 85)
                p.mv = MV_W'($urandom_range(0, 4095));
            else
                p.mv = MV_W'(int'(EDGE_MV[$urandom_range(0, NUM_EDGES - 1)])
                             + $urandom_range(0, 4) - 2);
            send_reading(p);
        end

        // drain, then watch for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("ntc_thermistor_linearizer verification clean");
        else
            $display("ntc_thermistor_linearizer verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/ntc_pkg.sv
sv/ntc_front.sv
sv/ntc_div_stage.sv
sv/ntc_seg.sv
sv/ntc_thermistor_linearizer.sv
bench/tb_top.sv
